// ===== hdl/mcpu_pkg.sv =====
// ---------------------------------------------------------------------------
// mcpu_pkg
// Shared types and constants for the microcoded 16-bit processor
// ---------------------------------------------------------------------------
`default_nettype none
package mcpu_pkg;
	localparam int MEM_WORDS_DEF   = 32768;
	localparam int CS_ROWS_DEF     = 64;
	localparam int NUM_GPRS_DEF    = 8;
	localparam int READY_AFTER_DEF = 4;
	localparam int MW_W            = 35;
	localparam logic [5:0] RESET_STATE = 6'd18;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_CS_WR = 2'd1,
		OP_MEM_WR = 2'd2,
		OP_SET_PC = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1
	} fsm_t;

	// sign extend the low bits of a value to 16 bits
	function automatic logic [15:0] sext6(input logic [5:0] v);
		sext6 = {{10{v[5]}}, v};
	endfunction
	function automatic logic [15:0] sext9(input logic [8:0] v);
		sext9 = {{7{v[8]}}, v};
	endfunction
	function automatic logic [15:0] sext11(input logic [10:0] v);
		sext11 = {{5{v[10]}}, v};
	endfunction
	function automatic logic [15:0] sext8(input logic [7:0] v);
		sext8 = {{8{v[7]}}, v};
	endfunction
endpackage
`default_nettype wire

// ===== hdl/microcoded_16bit_cpu_cycle.sv =====
// each request first reads the control store and memory word, then latches the
// datapath in the execute step; a stalled result holds the latch step
// a new request is accepted only after the previous one leaves the execute step
// reset: after reset a clearing pass writes zero to every word of main memory,
// during which no request is accepted
// ---------------------------------------------------------------------------
// microcoded_16bit_cpu_cycle
// Microprogrammed 16-bit processor, one emulated cycle per tick request
// ---------------------------------------------------------------------------
`default_nettype none
module microcoded_16bit_cpu_cycle import mcpu_pkg::*; #(
	parameter int MEM_WORDS   = MEM_WORDS_DEF,
	parameter int READY_AFTER = READY_AFTER_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [14:0] addr,
	input  wire logic [34:0] data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      pc_value,
	output logic [15:0]      ir_value,
	output logic [15:0]      mar_value,
	output logic [15:0]      mdr_value,
	output logic [15:0]      bus_value,
	output logic [5:0]       micro_state,
	output logic [2:0]       flags_nzp,
	output logic             branch_enable,
	output logic             mem_ready,
	output logic [15:0]      reg_value,
	output logic             halted
);
	localparam int MA_W = $clog2(MEM_WORDS);
	localparam int CL_W = $clog2(MEM_WORDS + 1);
	localparam logic [2:0] RDY_CNT = 3'(READY_AFTER);

	// memories
	logic [34:0] cs_mem [CS_ROWS_DEF];
	logic [15:0] main_mem [MEM_WORDS];
	logic [34:0] mw_s1;
	logic [15:0] mword_s1;

	// architectural state
	logic [15:0] gpr_q [NUM_GPRS_DEF];
	logic [15:0] pc_q, ir_q, mar_q, mdr_q;
	logic [2:0]  cc_q, wait_q;
	logic        ben_q, rdy_q;
	logic [5:0]  st_q;

	// request held for the execute step
	logic [1:0]  op_s1;
	logic [14:0] addr_s1;
	logic [34:0] data_s1;

	fsm_t        fsm_q, fsm_d;
	logic [CL_W-1:0] clr_q;
	logic        clr_busy;
	logic        res_full_q;
	logic        res_hold;
	logic        take, fin;

	assign clr_busy = (clr_q != CL_W'(MEM_WORDS));
	// a stalled result holds the execute step until the output side frees it
	assign res_hold = res_full_q && out_stall;
	assign fin      = (fsm_q == ST_EXEC) && !res_hold;
	assign in_stall = clr_busy || (fsm_q != ST_IDLE);
	assign take     = in_valid && !in_stall;
	assign out_valid = res_full_q;

	// next state
	always_comb begin
		fsm_d = fsm_q;
		case (fsm_q)
			ST_IDLE: if (take) fsm_d = ST_EXEC;
			ST_EXEC: if (!res_hold) fsm_d = ST_IDLE;
			default: fsm_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= ST_IDLE;
		end else begin
			fsm_q <= fsm_d;
		end
	end

	// control store and memory word reads, and capture of the request
	always_ff @(posedge clk) begin
		mw_s1    <= cs_mem[st_q];
		mword_s1 <= main_mem[mar_q[MA_W:1]];
		if (take) begin
			op_s1   <= opcode;
			addr_s1 <= addr;
			data_s1 <= data;
		end
	end

	// microword fields
	logic        ird, ld_mar, ld_mdr, ld_ir, ld_ben, ld_reg, ld_cc, ld_pc;
	logic        g_pc, g_mdr, g_alu, g_mm, g_shf, drmux, sr1mux, a1mux, marmux;
	logic        mio, rw, dsz, lshf;
	logic [1:0]  cnd, pcmux, a2mux, aluk;
	logic [5:0]  jf;
	assign ird = mw_s1[34];  assign cnd = mw_s1[33:32]; assign jf = mw_s1[31:26];
	assign ld_mar = mw_s1[25]; assign ld_mdr = mw_s1[24]; assign ld_ir = mw_s1[23];
	assign ld_ben = mw_s1[22]; assign ld_reg = mw_s1[21]; assign ld_cc = mw_s1[20];
	assign ld_pc = mw_s1[19];  assign g_pc = mw_s1[18];   assign g_mdr = mw_s1[17];
	assign g_alu = mw_s1[16];  assign g_mm = mw_s1[15];   assign g_shf = mw_s1[14];
	assign pcmux = mw_s1[13:12]; assign drmux = mw_s1[11]; assign sr1mux = mw_s1[10];
	assign a1mux = mw_s1[9];   assign a2mux = mw_s1[8:7]; assign marmux = mw_s1[6];
	assign aluk = mw_s1[5:4];  assign mio = mw_s1[3];     assign rw = mw_s1[2];
	assign dsz = mw_s1[1];     assign lshf = mw_s1[0];

	// datapath
	logic [15:0] sr1, sr2b, a2, adder, alu, shf, bus, mdr_rd, wr_word;
	logic [5:0]  nst;
	logic [2:0]  nwait;
	logic        nrdy, tick, mem_wr, nben;
	always_comb begin
		sr1 = gpr_q[sr1mux ? ir_q[8:6] : ir_q[11:9]];
		case (a2mux)
			2'd1: a2 = sext6(ir_q[5:0]);
			2'd2: a2 = sext9(ir_q[8:0]);
			2'd3: a2 = sext11(ir_q[10:0]);
			default: a2 = 16'd0;
		endcase
		if (lshf) a2 = {a2[14:0], 1'b0};
		adder = (a1mux ? sr1 : pc_q) + a2;
		sr2b = ir_q[5] ? {{11{ir_q[4]}}, ir_q[4:0]} : gpr_q[ir_q[2:0]];
		case (aluk)
			2'd0: alu = sr1 + sr2b;
			2'd1: alu = sr1 & sr2b;
			2'd2: alu = sr1 ^ sr2b;
			default: alu = sr1;
		endcase
		if (!ir_q[4]) shf = sr1 << ir_q[3:0];
		else if (ir_q[5]) shf = 16'($signed(sr1) >>> ir_q[3:0]);
		else shf = sr1 >> ir_q[3:0];
		if (g_mm) bus = marmux ? adder : {7'd0, ir_q[7:0], 1'b0};
		else if (g_pc) bus = pc_q;
		else if (g_alu) bus = alu;
		else if (g_shf) bus = shf;
		else if (g_mdr) bus = dsz ? mdr_q : sext8(mdr_q[7:0]);
		else bus = 16'd0;
		if (ird) nst = {2'b00, ir_q[15:12]};
		else nst = jf | {3'b000, (cnd == 2'd2) && ben_q, (cnd == 2'd1) && rdy_q,
			(cnd == 2'd3) && ir_q[11]};
		nben = (ir_q[11] && cc_q[2]) || (ir_q[10] && cc_q[1]) || (ir_q[9] && cc_q[0]);
		nwait = wait_q + 3'd1;
		nrdy = rdy_q || (nwait == RDY_CNT);
		if (rdy_q) begin
			nwait = 3'd0;
			nrdy = 1'b0;
		end
		mem_wr = mio && rdy_q && rw;
		if (dsz) wr_word = mdr_q;
		else if (mar_q[0]) wr_word = {mdr_q[7:0], mword_s1[7:0]};
		else wr_word = {mword_s1[15:8], mdr_q[7:0]};
		// a write lands before a read in the same cycle
		mdr_rd = mem_wr ? wr_word : mword_s1;
		tick = fin && (op_s1 == OP_TICK) && (pc_q != 16'd0);
	end

	// memory writes: clearing pass, loader, datapath store, control store load
	always_ff @(posedge clk) begin
		if (clr_busy) main_mem[clr_q[MA_W-1:0]] <= 16'd0;
		else if (fin && op_s1 == OP_MEM_WR && 32'(addr_s1) < MEM_WORDS)
			main_mem[addr_s1[MA_W-1:0]] <= data_s1[15:0];
		else if (tick && mem_wr) main_mem[mar_q[MA_W:1]] <= wr_word;
		if (fin && op_s1 == OP_CS_WR && addr_s1 < 15'(CS_ROWS_DEF))
			cs_mem[addr_s1[5:0]] <= data_s1;
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (clr_busy) clr_q <= clr_q + CL_W'(1);
	end

	// latch the datapath state, or load PC on a PC request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0; ir_q <= '0; mar_q <= '0; mdr_q <= '0;
			cc_q <= 3'b010; ben_q <= 1'b0; rdy_q <= 1'b0; wait_q <= '0;
			st_q <= RESET_STATE;
			for (int i = 0; i < NUM_GPRS_DEF; i++) gpr_q[i] <= '0;
		end else if (fin && op_s1 == OP_SET_PC) begin
			pc_q <= data_s1[15:0];
		end else if (tick) begin
			st_q <= nst;
			if (ld_ben) ben_q <= nben;
			if (mio) begin
				wait_q <= nwait;
				rdy_q <= nrdy;
			end
			if (ld_mar) mar_q <= bus;
			if (ld_ir) ir_q <= bus;
			if (ld_mdr) begin
				if (mio) begin
					if (rdy_q) mdr_q <= dsz ? mdr_rd :
						sext8(mar_q[0] ? mdr_rd[15:8] : mdr_rd[7:0]);
				end else mdr_q <= dsz ? bus : {8'd0, bus[7:0]};
			end
			if (ld_pc) begin
				case (pcmux)
					2'd0: pc_q <= pc_q + 16'd2;
					2'd1: pc_q <= bus;
					2'd2: pc_q <= adder;
					default: pc_q <= pc_q;
				endcase
			end
			if (ld_cc) cc_q <= (bus == 16'd0) ? 3'b010 : (bus[15] ? 3'b100 : 3'b001);
			if (ld_reg) gpr_q[drmux ? 3'd7 : ir_q[11:9]] <= bus;
		end
	end

	// result register
	logic [15:0] bus_q;
	logic [2:0]  rsel_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_full_q <= 1'b0;
		else if (fin) res_full_q <= 1'b1;
		else if (!out_stall) res_full_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (fin) begin
			bus_q  <= tick ? bus : 16'd0;
			rsel_q <= addr_s1[2:0];
		end
	end

	assign pc_value      = pc_q;
	assign ir_value      = ir_q;
	assign mar_value     = mar_q;
	assign mdr_value     = mdr_q;
	assign bus_value     = bus_q;
	assign micro_state   = st_q;
	assign flags_nzp     = cc_q;
	assign branch_enable = ben_q;
	assign mem_ready     = rdy_q;
	assign reg_value     = gpr_q[rsel_q];
	assign halted        = (pc_q == 16'd0);
endmodule
`default_nettype wire

// ===== tb/sv/microcoded_16bit_cpu_cycle_tb.sv =====
// ---------------------------------------------------------------------------
// microcoded_16bit_cpu_cycle_tb
// Drives tick, control-store, memory and PC requests into the processor,
// predicts every emulated cycle in a local datapath model and checks each
// reported register view field by field, under random idling on both sides
// ---------------------------------------------------------------------------
`default_nettype none
module microcoded_16bit_cpu_cycle_tb;
	import mcpu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 400000;

	// microword field masks
	localparam logic [34:0] M_LD_MAR  = 35'd1 << 25;
	localparam logic [34:0] M_LD_MDR  = 35'd1 << 24;
	localparam logic [34:0] M_LD_IR   = 35'd1 << 23;
	localparam logic [34:0] M_LD_BEN  = 35'd1 << 22;
	localparam logic [34:0] M_LD_REG  = 35'd1 << 21;
	localparam logic [34:0] M_LD_CC   = 35'd1 << 20;
	localparam logic [34:0] M_LD_PC   = 35'd1 << 19;
	localparam logic [34:0] M_G_PC    = 35'd1 << 18;
	localparam logic [34:0] M_G_MDR   = 35'd1 << 17;
	localparam logic [34:0] M_G_ALU   = 35'd1 << 16;
	localparam logic [34:0] M_G_MARMX = 35'd1 << 15;
	localparam logic [34:0] M_G_SHF   = 35'd1 << 14;
	localparam logic [34:0] M_DRMUX   = 35'd1 << 11;
	localparam logic [34:0] M_MIO     = 35'd1 << 3;
	localparam logic [34:0] M_RW      = 35'd1 << 2;
	localparam logic [34:0] M_WORD    = 35'd1 << 1;
	localparam logic [34:0] M_LSHF1   = 35'd1;
	localparam logic [34:0] J_HOLD    = 35'(RESET_STATE) << 26;

	typedef struct packed {
		logic [15:0] pc;
		logic [15:0] ir;
		logic [15:0] mar;
		logic [15:0] mdr;
		logic [15:0] bus;
		logic [5:0]  st;
		logic [2:0]  nzp;
		logic        ben;
		logic        rdy;
		logic [15:0] rv;
		logic        hlt;
	} cpu_view_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = '0;
	logic [14:0] addr = '0;
	logic [34:0] data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] pc_value, ir_value, mar_value, mdr_value, bus_value, reg_value;
	logic [5:0]  micro_state;
	logic [2:0]  flags_nzp;
	logic        branch_enable, mem_ready, halted;

	// model state of the processor
	logic [34:0] cstore [CS_ROWS_DEF];
	logic [15:0] mem_img [MEM_WORDS_DEF];
	logic [15:0] gpr [NUM_GPRS_DEF];
	logic [15:0] pc_r, ir_r, mar_r, mdr_r;
	logic [2:0]  cc_r, wait_r;
	logic        ben_r, rdy_r;
	logic [5:0]  state_r;

	cpu_view_t pending_views[$];
	int        errs = 0;
	int        cyc = 0;
	int        snd_idle_pct = 0;
	int        rcv_idle_pct = 0;

	microcoded_16bit_cpu_cycle u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .addr(addr), .data(data),
		.out_valid(out_valid), .out_stall(out_stall),
		.pc_value(pc_value), .ir_value(ir_value), .mar_value(mar_value),
		.mdr_value(mdr_value), .bus_value(bus_value), .micro_state(micro_state),
		.flags_nzp(flags_nzp), .branch_enable(branch_enable), .mem_ready(mem_ready),
		.reg_value(reg_value), .halted(halted)
	);

	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("microcoded_16bit_cpu_cycle: mismatch");
			$finish;
		end
	end

	// datapath helpers
	function automatic logic [15:0] sr1_of(input logic [34:0] mw);
		return mw[10] ? gpr[ir_r[8:6]] : gpr[ir_r[11:9]];
	endfunction

	function automatic logic [15:0] eff_addr(input logic [34:0] mw);
		logic [15:0] off;
		logic [15:0] base;
		case (mw[8:7])
			2'd1: off = {{10{ir_r[5]}}, ir_r[5:0]};
			2'd2: off = {{7{ir_r[8]}}, ir_r[8:0]};
			2'd3: off = {{5{ir_r[10]}}, ir_r[10:0]};
			default: off = '0;
		endcase
		if (mw[0])
			off = off << 1;
		base = mw[9] ? sr1_of(mw) : pc_r;
		return base + off;
	endfunction

	function automatic logic [15:0] alu_of(input logic [34:0] mw);
		logic [15:0] a;
		logic [15:0] b;
		a = sr1_of(mw);
		b = ir_r[5] ? {{11{ir_r[4]}}, ir_r[4:0]} : gpr[ir_r[2:0]];
		case (mw[5:4])
			2'd0: return a + b;
			2'd1: return a & b;
			2'd2: return a ^ b;
			default: return a;
		endcase
	endfunction

	function automatic logic [15:0] shift_of(input logic [34:0] mw);
		logic [15:0] v;
		v = sr1_of(mw);
		if (!ir_r[4])
			return v << ir_r[3:0];
		if (!ir_r[5])
			return v >> ir_r[3:0];
		return $signed(v) >>> ir_r[3:0];
	endfunction

	// one emulated clock cycle of the processor, returns the bus value
	function automatic logic [15:0] run_cycle();
		logic [34:0] mw;
		logic [14:0] midx;
		logic [15:0] bus, npc, nir, nmar, nmdr, w;
		logic [5:0]  nst;
		logic [2:0]  ncc, nwait;
		logic        nben, nrdy;
		mw = cstore[state_r];
		midx = mar_r[15:1];
		bus = '0;
		npc = pc_r; nir = ir_r; nmar = mar_r; nmdr = mdr_r;
		ncc = cc_r; nben = ben_r; nrdy = rdy_r; nwait = wait_r;

		// micro-sequencer
		if (mw[34]) begin
			nst = {2'b00, ir_r[15:12]};
		end else begin
			nst = mw[31:26];
			if (mw[33:32] == 2'd1 && rdy_r) nst[1] = 1'b1;
			if (mw[33:32] == 2'd2 && ben_r) nst[2] = 1'b1;
			if (mw[33:32] == 2'd3 && ir_r[11]) nst[0] = 1'b1;
		end
		if (mw[22])
			nben = (ir_r[11] & cc_r[2]) | (ir_r[10] & cc_r[1]) | (ir_r[9] & cc_r[0]);

		// memory timing and writes
		if (mw[3]) begin
			nwait = wait_r + 3'd1;
			if (nwait == 3'(READY_AFTER_DEF)) nrdy = 1'b1;
			if (rdy_r) begin
				if (mw[2]) begin
					if (mw[1])
						mem_img[midx] = mdr_r;
					else if (mar_r[0])
						mem_img[midx][15:8] = mdr_r[7:0];
					else
						mem_img[midx][7:0] = mdr_r[7:0];
				end
				nrdy = 1'b0;
				nwait = '0;
			end
		end

		// bus gates in priority order
		if (mw[15])
			bus = mw[6] ? eff_addr(mw) : {7'd0, ir_r[7:0], 1'b0};
		else if (mw[18]) bus = pc_r;
		else if (mw[16]) bus = alu_of(mw);
		else if (mw[14]) bus = shift_of(mw);
		else if (mw[17]) bus = mw[1] ? mdr_r : {{8{mdr_r[7]}}, mdr_r[7:0]};

		// latches
		if (mw[25]) nmar = bus;
		if (mw[23]) nir = bus;
		if (mw[24]) begin
			if (mw[3]) begin
				if (rdy_r) begin
					w = mem_img[midx];
					if (mw[1])
						nmdr = w;
					else if (mar_r[0])
						nmdr = {{8{w[15]}}, w[15:8]};
					else
						nmdr = {{8{w[7]}}, w[7:0]};
				end
			end else begin
				nmdr = mw[1] ? bus : {8'd0, bus[7:0]};
			end
		end
		if (mw[19]) begin
			case (mw[13:12])
				2'd0: npc = pc_r + 16'd2;
				2'd1: npc = bus;
				2'd2: npc = eff_addr(mw);
				default: npc = pc_r;
			endcase
		end
		if (mw[20])
			ncc = (bus == 0) ? 3'b010 : (bus[15] ? 3'b100 : 3'b001);
		if (mw[21])
			gpr[mw[11] ? 3'd7 : ir_r[11:9]] = bus;

		pc_r = npc; ir_r = nir; mar_r = nmar; mdr_r = nmdr;
		cc_r = ncc; ben_r = nben; rdy_r = nrdy; wait_r = nwait;
		state_r = nst;
		return bus;
	endfunction

	// apply one request to the model and return the view it should produce
	function automatic cpu_view_t emulate_request(input op_t op, input logic [14:0] a,
			input logic [34:0] d);
		cpu_view_t v;
		logic [15:0] bus;
		bus = '0;
		case (op)
			OP_TICK:   if (pc_r != 0) bus = run_cycle();
			OP_CS_WR:  if (a < CS_ROWS_DEF) cstore[a[5:0]] = d;
			OP_MEM_WR: mem_img[a] = d[15:0];
			default:   pc_r = d[15:0];
		endcase
		v.pc = pc_r; v.ir = ir_r; v.mar = mar_r; v.mdr = mdr_r; v.bus = bus;
		v.st = state_r; v.nzp = cc_r; v.ben = ben_r; v.rdy = rdy_r;
		v.rv = gpr[a[2:0]]; v.hlt = (pc_r == 0);
		return v;
	endfunction

	// send one request, at random with a random gap in front of it
	task automatic send_request(input op_t op, input logic [14:0] a, input logic [34:0] d);
		if ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		addr <= a;
		data <= d;
		do @(posedge clk); while (in_stall);
		pending_views.push_back(emulate_request(op, a, d));
	endtask

	task automatic drain_views();
		in_valid <= 1'b0;
		while (pending_views.size() != 0) @(posedge clk);
	endtask

	function automatic logic [34:0] rand_microword();
		logic [34:0] mw;
		mw = 35'({$urandom, $urandom});
		if ($urandom_range(7) != 0) mw[34] = 1'b0;
		return mw;
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rcv_idle_pct);
	end

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s expected %h actual %h", name, exp_v, act_v);
			errs++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		cpu_view_t e;
		if (out_valid && !out_stall) begin
			if (pending_views.size() == 0) begin
				$error("unexpected result, pc_value %h", pc_value);
				errs++;
			end else begin
				e = pending_views.pop_front();
				check_field("pc_value", e.pc, pc_value);
				check_field("ir_value", e.ir, ir_value);
				check_field("mar_value", e.mar, mar_value);
				check_field("mdr_value", e.mdr, mdr_value);
				check_field("bus_value", e.bus, bus_value);
				check_field("micro_state", 16'(e.st), 16'(micro_state));
				check_field("flags_nzp", 16'(e.nzp), 16'(flags_nzp));
				check_field("branch_enable", 16'(e.ben), 16'(branch_enable));
				check_field("mem_ready", 16'(e.rdy), 16'(mem_ready));
				check_field("reg_value", e.rv, reg_value);
				check_field("halted", 16'(e.hlt), 16'(halted));
			end
		end
	end

	// every control row gets a microword before any tick runs
	task automatic test_load_microcode();
		for (int r = 0; r < CS_ROWS_DEF; r++)
			send_request(OP_CS_WR, 15'(r), rand_microword());
	endtask

	// hand-built microwords held in the reset state row
	task automatic test_directed_datapath();
		send_request(OP_SET_PC, 15'd0, 35'h0_8C35);
		send_request(OP_CS_WR, 15'(RESET_STATE), J_HOLD | M_LD_IR | M_LD_MAR | M_LD_CC | M_G_PC);
		send_request(OP_TICK, 15'd6, '0);
		for (int k = 0; k < 4; k++) begin
			send_request(OP_CS_WR, 15'(RESET_STATE), J_HOLD | M_G_ALU | M_LD_REG | M_LD_CC |
				M_LD_BEN | (35'(k) << 4) | (k[0] ? M_DRMUX : '0));
			send_request(OP_TICK, 15'(k + 6), '0);
		end
		// arithmetic right shift mode, applied to a source register that is zero by now
		send_request(OP_CS_WR, 15'(RESET_STATE), J_HOLD | M_G_SHF | M_LD_REG | M_LD_CC);
		send_request(OP_TICK, 15'd6, '0);
		// every gate at once, trap vector wins and lands in PC
		send_request(OP_CS_WR, 15'(RESET_STATE), J_HOLD | M_G_MARMX | M_G_PC | M_G_ALU |
			M_G_SHF | M_G_MDR | M_LD_PC | (35'd1 << 12) | M_LD_MDR | M_LD_MAR | M_LSHF1);
		send_request(OP_TICK, 15'd7, '0);
		// word write through memory wait states, with MDR loaded from the written word
		send_request(OP_CS_WR, 15'(RESET_STATE), J_HOLD | M_MIO | M_RW | M_WORD | M_LD_MDR);
		repeat (5) send_request(OP_TICK, 15'd0, '0);
	endtask

	task automatic test_halt_and_ignored_writes();
		send_request(OP_SET_PC, 15'd0, '0);
		send_request(OP_TICK, 15'd3, '1);
		send_request(OP_CS_WR, 15'h7FFF, '1);
		send_request(OP_MEM_WR, 15'h7FFF, '1);
		send_request(OP_MEM_WR, 15'd0, 35'h0_FFFF);
		send_request(OP_SET_PC, 15'd0, 35'h0_FFFF);
	endtask

	// mostly ticks over random microcode, with reloads, memory writes and PC changes mixed in
	task automatic test_random_program(input int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pc_r == 0 && $urandom_range(9) < 8)
				send_request(OP_SET_PC, 15'($urandom), 35'({$urandom, $urandom}) | 35'h1);
			else if (pick < 75)
				send_request(OP_TICK, 15'($urandom), 35'({$urandom, $urandom}));
			else if (pick < 83)
				send_request(OP_CS_WR, ($urandom_range(9) == 0) ? 15'($urandom) :
					15'($urandom_range(CS_ROWS_DEF - 1)), rand_microword());
			else if (pick < 93)
				send_request(OP_MEM_WR, 15'($urandom), 35'({$urandom, $urandom}));
			else
				send_request(OP_SET_PC, 15'($urandom),
					($urandom_range(4) == 0) ? 35'd0 : 35'({$urandom, $urandom}));
		end
	endtask

	initial begin
		for (int i = 0; i < MEM_WORDS_DEF; i++) mem_img[i] = '0;
		for (int i = 0; i < NUM_GPRS_DEF; i++) gpr[i] = '0;
		for (int i = 0; i < CS_ROWS_DEF; i++) cstore[i] = '0;
		pc_r = '0; ir_r = '0; mar_r = '0; mdr_r = '0;
		cc_r = 3'b010; ben_r = 1'b0; rdy_r = 1'b0; wait_r = '0;
		state_r = RESET_STATE;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_load_microcode();
		test_directed_datapath();
		test_halt_and_ignored_writes();
		// sender pauses until every result is back
		drain_views();

		snd_idle_pct = 16; rcv_idle_pct = 58;
		test_random_program(380);
		snd_idle_pct = 58; rcv_idle_pct = 16;
		test_random_program(380);
		snd_idle_pct = 0; rcv_idle_pct = 0;
		test_random_program(390);

		drain_views();
		repeat (10) @(posedge clk);
		if (errs == 0)
			$display("microcoded_16bit_cpu_cycle: match");
		else
			$display("microcoded_16bit_cpu_cycle: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
